// File: sv/depth_tested_pixel_store_macros.svh
// Assertion macros used by the depth-tested pixel store checker.
// No dependencies; every macro expects clk and rst_n in scope.
`ifndef DEPTH_TESTED_PIXEL_STORE_MACROS_SVH
`define DEPTH_TESTED_PIXEL_STORE_MACROS_SVH

// Same-cycle implication, quiet while reset is held
`define DTPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held
`define DTPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dtps_pkg.sv
// Shared types and constants for the depth-tested pixel store.
// No dependencies.
`timescale 1ns / 1ps

package dtps_pkg;

    // Fixed field widths
    localparam int OP_W      = 2;
    localparam int POS_W     = 8;
    localparam int DEPTH_W   = 24;
    localparam int COLOR_W   = 32;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PLOT  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input beat taken, latch item and read store
        logic commit;   // finish a plot/read, write back and load result
        logic walk;     // clear one store entry
        logic finish;   // load the clear-done result
    } dtps_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_last; // walk pointer sits on the final entry
    } dtps_sts_t;

endpackage

// File: sv/depth_tested_pixel_store.sv
// Depth-tested pixel store (z-buffer): top level joining controller and datapath.
// Depends on dtps_pkg, dtps_ctrl and dtps_datapath.
`timescale 1ns / 1ps

// Holds MAX_WIDTH*MAX_HEIGHT pixels of RGBA color, depth and an occupied bit;
// pixel (x, y) is entry x + y*MAX_WIDTH. A plot or read is accepted, then
// commits once the output slot is free, and no new item is taken until it
// has committed: the store is read when the beat is accepted and written
// back at commit, through the single port of each pixel memory. A clear
// walks the store one entry per cycle, then loads the done result once the
// output slot is free, and the output register presents it. After reset the
// same walk runs once with in_ready low; size registers can be written
// during it. A finished result sits in an output register, so the next
// item is taken while that beat waits for out_ready.
module depth_tested_pixel_store #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [dtps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dtps_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dtps_pkg::OP_W-1:0]      op,
    input  logic [dtps_pkg::POS_W-1:0]     pos_x,
    input  logic [dtps_pkg::POS_W-1:0]     pos_y,
    input  logic [dtps_pkg::DEPTH_W-1:0]   frag_depth,
    input  logic [dtps_pkg::COLOR_W-1:0]   frag_color,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dtps_pkg::COLOR_W-1:0]   read_color,
    output logic [dtps_pkg::DEPTH_W-1:0]   read_depth,
    output logic                          read_set,
    output logic                          wrote,
    output logic                          off_screen,
    output logic                          clear_done
);
    import dtps_pkg::*;

    dtps_cmd_t cmd;
    dtps_sts_t sts;

    dtps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    dtps_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .frag_depth (frag_depth),
        .frag_color (frag_color),
        .read_color (read_color),
        .read_depth (read_depth),
        .read_set   (read_set),
        .wrote      (wrote),
        .off_screen (off_screen),
        .clear_done (clear_done),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

// File: sv/dtps_ctrl.sv
// Controller for the depth-tested pixel store: sequencing and output valid.
// Depends on dtps_pkg.
`timescale 1ns / 1ps

module dtps_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [dtps_pkg::OP_W-1:0] op,
    output logic                    out_valid,
    input  logic                    out_ready,
    output dtps_pkg::dtps_cmd_t     cmd,
    input  dtps_pkg::dtps_sts_t     sts
);
    import dtps_pkg::*;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // Output slot can take a result this cycle
    assign slot_free = !out_valid_reg || out_ready;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cmd.accept = in_valid && (state_reg == ST_IDLE);
    assign cmd.walk   = (state_reg == ST_INIT) || (state_reg == ST_WALK);
    assign cmd.commit = (state_reg == ST_LOOK) && slot_free;
    assign cmd.finish = (state_reg == ST_FIN) && slot_free;
    assign out_valid  = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sts.walk_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (op == OP_CLEAR) ? ST_WALK : ST_LOOK;
            end
            ST_LOOK:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (sts.walk_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Result slot occupancy
    always_comb
    begin
        if (cmd.commit || cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/dtps_datapath.sv
// Datapath for the depth-tested pixel store: size registers, pixel memories,
// depth test, clear pointer and result register. Depends on dtps_pkg.
`timescale 1ns / 1ps

module dtps_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DEPTH_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [dtps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dtps_pkg::CFG_W-1:0]     cfg_data,
    input  logic [dtps_pkg::OP_W-1:0]      op,
    input  logic [dtps_pkg::POS_W-1:0]     pos_x,
    input  logic [dtps_pkg::POS_W-1:0]     pos_y,
    input  logic [dtps_pkg::DEPTH_W-1:0]   frag_depth,
    input  logic [dtps_pkg::COLOR_W-1:0]   frag_color,
    output logic [dtps_pkg::COLOR_W-1:0]   read_color,
    output logic [dtps_pkg::DEPTH_W-1:0]   read_depth,
    output logic                          read_set,
    output logic                          wrote,
    output logic                          off_screen,
    output logic                          clear_done,
    input  dtps_pkg::dtps_cmd_t           cmd,
    output dtps_pkg::dtps_sts_t           sts
);
    import dtps_pkg::*;

    localparam int ENTRIES = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int HW      = $clog2(MAX_HEIGHT + 1);
    localparam int SD_W    = (DEPTH_BITS < DEPTH_W) ? DEPTH_BITS : DEPTH_W;
    localparam int W_RST   = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int H_RST   = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

    // Clamp a written size into 1..max
    function automatic logic [31:0] clamp_size(input logic [CFG_W-1:0] v,
                                               input int unsigned lim);
        logic [31:0] r;
        begin
            r = 32'(v);
            if (r == 32'd0)
                r = 32'd1;
            else if (r > lim)
                r = 32'(lim);
            return r;
        end
    endfunction

    logic [WW-1:0]      width_reg;
    logic [HW-1:0]      height_reg;
    logic [ADDR_W-1:0]  clear_idx_reg;

    logic [COLOR_W-1:0] color_mem [ENTRIES];
    logic               occ_mem   [ENTRIES];
    logic [SD_W-1:0]    depth_mem [ENTRIES];

    logic [OP_W-1:0]    op_reg;
    logic               on_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [SD_W-1:0]    depth_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] rd_color_reg;
    logic [SD_W-1:0]    rd_depth_reg;
    logic               rd_occ_reg;

    logic [COLOR_W-1:0] read_color_reg;
    logic [DEPTH_W-1:0] read_depth_reg;
    logic               read_set_reg;
    logic               wrote_reg;
    logic               off_screen_reg;
    logic               clear_done_reg;

    logic [ADDR_W-1:0]  acc_addr;
    logic               acc_on;
    logic               plot_pass;
    logic [COLOR_W-1:0] res_color;
    logic [DEPTH_W-1:0] res_depth;
    logic               res_set;
    logic               res_wrote;
    logic               res_off;

    // Entry address and on-screen check for the beat at the port
    assign acc_addr = ADDR_W'(32'(pos_x) + 32'(pos_y) * MAX_WIDTH);
    assign acc_on   = (32'(pos_x) < 32'(width_reg)) && (32'(pos_y) < 32'(height_reg));

    assign sts.walk_last = (clear_idx_reg == ADDR_W'(ENTRIES - 1));

    // Size registers, clamped on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(W_RST);
            height_reg <= HW'(H_RST);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= WW'(clamp_size(cfg_data, MAX_WIDTH));
                REG_HEIGHT: height_reg <= HW'(clamp_size(cfg_data, MAX_HEIGHT));
                default:    ;
            endcase
        end
    end

    // Walk pointer, wraps after the last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_idx_reg <= '0;
        else if (cmd.walk)
            clear_idx_reg <= sts.walk_last ? '0 : clear_idx_reg + ADDR_W'(1);
    end

    // Item latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= op;
            on_reg    <= acc_on;
            addr_reg  <= acc_addr;
            depth_reg <= frag_depth[SD_W-1:0];
            color_reg <= frag_color;
        end
    end

    // Depth test on the registered store read
    assign plot_pass = (op_reg == OP_PLOT) && on_reg && (depth_reg != '0)
                       && (!rd_occ_reg || (depth_reg < rd_depth_reg));

    // Color and occupancy memories: clear walk or plot write-back
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_color_reg <= color_mem[acc_addr];
            rd_occ_reg   <= occ_mem[acc_addr];
        end
        if (cmd.walk)
        begin
            color_mem[clear_idx_reg] <= COLOR_WHITE;
            occ_mem[clear_idx_reg]   <= 1'b0;
        end
        else if (cmd.commit && plot_pass)
        begin
            color_mem[addr_reg] <= color_reg;
            occ_mem[addr_reg]   <= 1'b1;
        end
    end

    // Depth memory, written by plots only
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            rd_depth_reg <= depth_mem[acc_addr];
        if (cmd.commit && plot_pass)
            depth_mem[addr_reg] <= depth_reg;
    end

    // Result fields for a plot or read
    always_comb
    begin
        res_color = '0;
        res_depth = '0;
        res_set   = 1'b0;
        res_wrote = 1'b0;
        res_off   = 1'b0;
        unique case (op_reg)
            OP_PLOT:
            begin
                res_off   = !on_reg;
                res_wrote = plot_pass;
            end
            OP_READ:
            begin
                if (!on_reg)
                    res_off = 1'b1;
                else
                begin
                    res_color = rd_color_reg;
                    res_set   = rd_occ_reg;
                    if (rd_occ_reg)
                        res_depth = DEPTH_W'(rd_depth_reg);
                end
            end
            default:
            begin
                res_off = 1'b0;
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_color_reg <= '0;
            read_depth_reg <= '0;
            read_set_reg   <= 1'b0;
            wrote_reg      <= 1'b0;
            off_screen_reg <= 1'b0;
            clear_done_reg <= 1'b1;
        end
        else if (cmd.commit)
        begin
            read_color_reg <= res_color;
            read_depth_reg <= res_depth;
            read_set_reg   <= res_set;
            wrote_reg      <= res_wrote;
            off_screen_reg <= res_off;
            clear_done_reg <= 1'b0;
        end
    end

    assign read_color = read_color_reg;
    assign read_depth = read_depth_reg;
    assign read_set   = read_set_reg;
    assign wrote      = wrote_reg;
    assign off_screen = off_screen_reg;
    assign clear_done = clear_done_reg;

endmodule

// File: sv/dtps_checker.sv
// Port-level checker for the depth-tested pixel store, bound to the top level.
// Depends on dtps_pkg and depth_tested_pixel_store_macros.svh.
`timescale 1ns / 1ps
`include "depth_tested_pixel_store_macros.svh"

module dtps_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dtps_pkg::COLOR_W-1:0]   read_color,
    input logic [dtps_pkg::DEPTH_W-1:0]   read_depth,
    input logic                          read_set,
    input logic                          wrote,
    input logic                          off_screen,
    input logic                          clear_done
);

    // Off-screen beat carries nothing else
    `DTPS_ASSERT_NOW(a_off_clean, out_valid && off_screen, read_color == '0 && read_depth == '0 && !read_set && !wrote && !clear_done, "off-screen beat has other fields set")

    // Empty pixel reports no depth
    `DTPS_ASSERT_NOW(a_empty_depth, out_valid && !read_set, read_depth == '0, "depth shown for an empty pixel")

    // Clear-done beat carries nothing else
    `DTPS_ASSERT_NOW(a_clear_clean, out_valid && clear_done, read_color == '0 && !read_set && !wrote && !off_screen, "clear-done beat has other fields set")

    // Stalled result beat holds its color, depth and wrote fields
    `DTPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_color) && $stable(read_depth) && $stable(wrote), "result beat changed while stalled")

endmodule

bind depth_tested_pixel_store dtps_checker u_dtps_checker (.*);
